FILE: design/mm64_pkg.sv
// Shared types and constants for the MurmurHash64A byte-stream hasher.
// Used by the constant multiplier unit and by the top-level sequencer.
// No dependencies.
package mm64_pkg;

    // Magic multiplier and mixing shift of the 64-bit Murmur variant.
    localparam logic [63:0] MAGIC_MULT = 64'hC6A4_A793_5BD1_E995;
    localparam int unsigned MIX_SHIFT = 47;

    // Request into the shared multiplier: one pulse starts one product.
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mul_req;

    // Response from the shared multiplier: product is held until the next start.
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } t_mul_rsp;

    // Fold the high bits of a word back into its low bits.
    function automatic logic [63:0] fold_shift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

FILE: design/mm64_mul.sv
// Multiplies a 64-bit operand by the magic constant, modulo 2^64.
// One 32x32 multiplier is reused in three steps, one partial product per step.
// Depends on mm64_pkg.
module mm64_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mm64_pkg::t_mul_req i_req,
    output mm64_pkg::t_mul_rsp o_rsp
);
    import mm64_pkg::*;

    // Partial products in the order they are accumulated.
    typedef enum logic [2:0] {
        STEP_LO_LO = 3'b001,
        STEP_HI_LO = 3'b010,
        STEP_LO_HI = 3'b100
    } t_step;

    logic        r_busy;
    logic        r_done;
    t_step       r_step;
    logic [63:0] r_a;
    logic [63:0] r_acc;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;

    // Operand selection for the single 32x32 multiplier.
    always_comb begin
        unique case (r_step)
            STEP_LO_LO: begin
                op_a = r_a[31:0];
                op_b = MAGIC_MULT[31:0];
            end
            STEP_HI_LO: begin
                op_a = r_a[63:32];
                op_b = MAGIC_MULT[31:0];
            end
            STEP_LO_HI: begin
                op_a = r_a[31:0];
                op_b = MAGIC_MULT[63:32];
            end
            default: begin
                op_a = r_a[31:0];
                op_b = MAGIC_MULT[31:0];
            end
        endcase
    end

    // Both operands are 32 bits wide, so the product fits exactly in 64 bits.
    assign prod = 64'(op_a) * 64'(op_b);

    // Control: a start loads the operand and runs the three steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LO_LO;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LO_LO;
            end else if (r_busy) begin
                unique case (r_step)
                    STEP_LO_LO: r_step <= STEP_HI_LO;
                    STEP_HI_LO: r_step <= STEP_LO_HI;
                    STEP_LO_HI: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_step <= STEP_LO_LO;
                    end
                    default: r_step <= STEP_LO_LO;
                endcase
            end
        end
    end

    // Datapath: the cross terms only reach the upper half of the result.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end
        if (r_busy) begin
            if (r_step == STEP_LO_LO) begin
                r_acc <= prod;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + prod[31:0];
            end
        end
    end

    assign o_rsp = {r_done, r_acc};

endmodule

FILE: design/murmur64a_byte_hash.sv
// Top level of the streaming MurmurHash64A hasher: sequencer and hash state.
// Instantiates mm64_mul, the shared constant multiplier. Depends on mm64_pkg.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall  | first, seed, length, word, count, last
//  out     | source    | o_out_valid / i_out_stall| o_hash_value
//
// Every product by the magic constant runs on the shared multiplier.
// A middle chunk holds the input for three products plus dispatch; a first chunk
// adds the length product, and a last chunk adds the finalization product,
// with fewer products when its tail is short or empty.
// Reset is synchronous and clears the sequencer, output valid and the running hash.
// A finished hash waits in the output register under stall while the next chunk
// is accepted; finalization waits only if the previous hash is still stalled.
module murmur64a_byte_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_first_chunk,
    input  logic [63:0] i_seed_value,
    input  logic [31:0] i_total_length,
    input  logic [63:0] i_chunk_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_chunk,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);
    import mm64_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LEN   = 8'b0000_0010,
        S_ROUTE = 8'b0000_0100,
        S_KMUL1 = 8'b0000_1000,
        S_KMUL2 = 8'b0001_0000,
        S_HMUL  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic        r_issued, n_issued;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_out, n_out;
    logic [63:0] r_h, n_h;
    logic [63:0] r_k, n_k;
    logic [63:0] r_word, n_word;
    logic [63:0] r_seed, n_seed;
    logic [31:0] r_len, n_len;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_last, n_last;

    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;
    logic        mul_state;
    logic [5:0]  tail_bits;
    logic [63:0] tail_mask;

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Mask that keeps the valid bytes of a short tail.
    assign tail_bits = {r_cnt[2:0], 3'b000};
    assign tail_mask = (64'd1 << tail_bits) - 64'd1;

    // Multiplier requests: one start on entry to each multiply state.
    assign mul_state = (r_state == S_LEN) || (r_state == S_KMUL1) || (r_state == S_KMUL2)
                    || (r_state == S_HMUL) || (r_state == S_FIN);

    always_comb begin
        mul_req.start = mul_state && !r_issued;
        unique case (r_state)
            S_LEN:   mul_req.operand = {32'd0, r_len};
            S_KMUL1: mul_req.operand = r_word;
            S_KMUL2: mul_req.operand = r_k;
            S_HMUL:  mul_req.operand = r_h;
            S_FIN:   mul_req.operand = fold_shift(r_h);
            default: mul_req.operand = r_h;
        endcase
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_h      = r_h;
        n_k      = r_k;
        n_word   = r_word;
        n_seed   = r_seed;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_last   = r_last;

        if (mul_req.start) begin
            n_issued = 1'b1;
        end
        if (mul_rsp.done) begin
            n_issued = 1'b0;
        end

        // A completed output transfer frees the result register.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word  = i_chunk_word;
                    n_seed  = i_seed_value;
                    n_len   = i_total_length;
                    n_cnt   = i_byte_count;
                    n_last  = i_last_chunk;
                    n_state = i_first_chunk ? S_LEN : S_ROUTE;
                end
            end
            S_LEN: begin
                if (mul_rsp.done) begin
                    n_h     = r_seed ^ mul_rsp.product;
                    n_state = S_ROUTE;
                end
            end
            S_ROUTE: begin
                // Full chunks are premixed; a short tail is folded in raw.
                if (!r_last || r_cnt[3]) begin
                    n_state = S_KMUL1;
                end else if (r_cnt[2:0] != 3'd0) begin
                    n_h     = r_h ^ (r_word & tail_mask);
                    n_state = S_HMUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_KMUL1: begin
                if (mul_rsp.done) begin
                    n_k     = fold_shift(mul_rsp.product);
                    n_state = S_KMUL2;
                end
            end
            S_KMUL2: begin
                if (mul_rsp.done) begin
                    n_h     = r_h ^ mul_rsp.product;
                    n_state = S_HMUL;
                end
            end
            S_HMUL: begin
                if (mul_rsp.done) begin
                    n_h     = mul_rsp.product;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (mul_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // The product stays held in the multiplier until the slot frees.
                if (!r_ovalid || !i_out_stall) begin
                    n_out    = fold_shift(mul_rsp.product);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and the running hash.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_h      <= 64'd0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
            r_h      <= n_h;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_k    <= n_k;
        r_word <= n_word;
        r_seed <= n_seed;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_hash_value = r_out;

endmodule
